>>> rtl/core/xbic_pkg.sv
// Package for the x86 branch instruction classifier: opcode and prefix
// constants, the result record type and the prefix test.
// No dependencies.
package xbic_pkg;

   localparam int unsigned INSTR_BYTES = 8;
   localparam int unsigned INSTR_WIDTH = 8 * INSTR_BYTES;

   // Prefix bytes.
   localparam logic [7:0] PFX_ES      = 8'h26;
   localparam logic [7:0] PFX_CS      = 8'h2E;
   localparam logic [7:0] PFX_SS      = 8'h36;
   localparam logic [7:0] PFX_DS      = 8'h3E;
   localparam logic [7:0] PFX_FS      = 8'h64;
   localparam logic [7:0] PFX_GS      = 8'h65;
   localparam logic [7:0] PFX_OPSIZE  = 8'h66;
   localparam logic [7:0] PFX_ADSIZE  = 8'h67;
   localparam logic [7:0] PFX_LOCK    = 8'hF0;
   localparam logic [7:0] PFX_REPNE   = 8'hF2;
   localparam logic [7:0] PFX_REP     = 8'hF3;

   // Branch opcodes.
   localparam logic [7:0] OP_JCC_SHORT_LO = 8'h70;
   localparam logic [7:0] OP_JCC_SHORT_HI = 8'h7F;
   localparam logic [7:0] OP_JMP_FAR      = 8'hEA;
   localparam logic [7:0] OP_RET_IMM      = 8'hC2;
   localparam logic [7:0] OP_RET          = 8'hC3;
   localparam logic [7:0] OP_CALL_REL     = 8'hE8;
   localparam logic [7:0] OP_ENTER        = 8'hC8;
   localparam logic [7:0] OP_CALL_FAR     = 8'h9A;
   localparam logic [7:0] OP_GROUP5       = 8'hFF;
   localparam logic [7:0] OP_JMP_REL8     = 8'hEB;
   localparam logic [7:0] OP_JMP_REL32    = 8'hE9;
   localparam logic [7:0] OP_ESCAPE       = 8'h0F;
   localparam logic [7:0] OP_JECXZ        = 8'hE3;

   // Second byte of a near conditional jump after the escape byte.
   localparam logic [3:0] OP2_JCC_NEAR_HI = 4'h8;

   // ModRM reg field values of the FF group that branch.
   localparam logic [2:0] REG_CALL_NEAR = 3'd2;
   localparam logic [2:0] REG_CALL_FAR  = 3'd3;
   localparam logic [2:0] REG_JMP_NEAR  = 3'd4;
   localparam logic [2:0] REG_JMP_FAR   = 3'd5;

   localparam logic [2:0] DISP_SIZE_8  = 3'd1;
   localparam logic [2:0] DISP_SIZE_32 = 3'd4;

   typedef struct packed {
      logic       is_call;
      logic       is_abs_branch;
      logic       is_rel_branch;
      logic       is_cond;
      logic [2:0] disp_size;
      logic [2:0] disp_offset;
      logic [3:0] instr_length;
   } xbic_result_type;

   function automatic logic is_prefix(input logic [7:0] b);
      logic hit;
      begin
         case (b) inside
            PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
            PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

endpackage

>>> rtl/core/xbic_if.sv
// Handshake channels of the branch classifier: instruction window in and
// classification result out. Depends on xbic_pkg.
interface xbic_req_if
   import xbic_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [INSTR_WIDTH-1:0] instr_bytes;

   modport source (output valid, output instr_bytes, input ready);
   modport sink   (input valid, input instr_bytes, output ready);
endinterface

interface xbic_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_call;
   logic       is_abs_branch;
   logic       is_rel_branch;
   logic       is_cond;
   logic [2:0] disp_size;
   logic [2:0] disp_offset;
   logic [3:0] instr_length;

   modport source (output valid, output is_call, output is_abs_branch,
                   output is_rel_branch, output is_cond, output disp_size,
                   output disp_offset, output instr_length, input ready);
   modport sink   (input valid, input is_call, input is_abs_branch,
                   input is_rel_branch, input is_cond, input disp_size,
                   input disp_offset, input instr_length, output ready);
endinterface

>>> rtl/core/xbic_decode.sv
// Combinational decode of one instruction window: prefix skip, opcode
// classification and displacement geometry. Depends on xbic_pkg.
module xbic_decode
   import xbic_pkg::*;
#(
   parameter int unsigned MAX_PREFIXES = 4
) (
   input  logic [INSTR_WIDTH-1:0] instr_bytes,
   output xbic_result_type        result
);

   logic [7:0] bytes [INSTR_BYTES];
   logic [2:0] pos;
   logic       stop;
   logic [7:0] op;
   logic [7:0] modrm;
   logic [2:0] reg_field;

   always_comb begin
      for (int i = 0; i < INSTR_BYTES; i++) begin
         bytes[i] = instr_bytes[8*i +: 8];
      end
   end

   // Count leading prefix bytes, at most MAX_PREFIXES of them.
   always_comb begin
      pos  = 3'd0;
      stop = 1'b0;
      for (int i = 0; i < MAX_PREFIXES; i++) begin
         if (!stop && is_prefix(bytes[i])) begin
            pos = 3'(i + 1);
         end else begin
            stop = 1'b1;
         end
      end
   end

   assign op        = bytes[pos];
   assign modrm     = bytes[pos + 3'd1];
   assign reg_field = modrm[5:3];

   always_comb begin
      result = '0;
      case (op) inside
         [OP_JCC_SHORT_LO:OP_JCC_SHORT_HI], OP_JECXZ: begin
            result.is_cond       = 1'b1;
            result.is_rel_branch = 1'b1;
            result.disp_size     = DISP_SIZE_8;
            result.disp_offset   = pos + 3'd1;
         end
         OP_JMP_FAR, OP_RET_IMM, OP_RET: begin
            result.is_abs_branch = 1'b1;
         end
         OP_CALL_REL: begin
            result.is_call       = 1'b1;
            result.is_rel_branch = 1'b1;
            result.disp_size     = DISP_SIZE_32;
            result.disp_offset   = pos + 3'd1;
         end
         OP_ENTER, OP_CALL_FAR: begin
            result.is_call       = 1'b1;
            result.is_abs_branch = 1'b1;
         end
         OP_GROUP5: begin
            if (reg_field == REG_CALL_NEAR || reg_field == REG_CALL_FAR) begin
               result.is_call       = 1'b1;
               result.is_abs_branch = 1'b1;
            end else if (reg_field == REG_JMP_NEAR || reg_field == REG_JMP_FAR) begin
               result.is_abs_branch = 1'b1;
            end
         end
         OP_JMP_REL8: begin
            result.is_rel_branch = 1'b1;
            result.disp_size     = DISP_SIZE_8;
            result.disp_offset   = pos + 3'd1;
         end
         OP_JMP_REL32: begin
            result.is_rel_branch = 1'b1;
            result.disp_size     = DISP_SIZE_32;
            result.disp_offset   = pos + 3'd1;
         end
         OP_ESCAPE: begin
            if (modrm[7:4] == OP2_JCC_NEAR_HI) begin
               result.is_cond       = 1'b1;
               result.is_rel_branch = 1'b1;
               result.disp_size     = DISP_SIZE_32;
               result.disp_offset   = pos + 3'd2;
            end
         end
         default: begin
            result = '0;
         end
      endcase
      // Non-relative opcodes leave size and offset at zero, so the sum is zero too.
      result.instr_length = {1'b0, result.disp_offset} + {1'b0, result.disp_size};
   end

endmodule

>>> rtl/core/x86_branch_instruction_classifier.sv
// x86 branch instruction classifier, top level.
// A result passes the input register, then the result register, before it is offered.
// Throughput: one instruction per cycle, set by the single decode pass between the two registers,
// while rsp.ready lets the result register drain; otherwise the stages hold their content.
// Reset (synchronous, active high) empties both stages; no other state.
module x86_branch_instruction_classifier
   import xbic_pkg::*;
#(
   parameter int unsigned MAX_PREFIXES = 4
) (
   input  logic      clock,
   input  logic      reset,
   xbic_req_if.sink  req,
   xbic_rsp_if.source rsp
);

   logic                   in_valid_ff, in_valid_in;
   logic [INSTR_WIDTH-1:0] in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   xbic_result_type        out_data_ff;
   xbic_result_type        decoded;
   logic                   out_take;

   // The result stage can load when it is empty or its content is leaving.
   assign out_take     = !out_valid_ff || rsp.ready;
   assign req.ready    = !in_valid_ff || out_take;
   assign in_valid_in  = req.ready ? req.valid : in_valid_ff;
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   xbic_decode #(
      .MAX_PREFIXES(MAX_PREFIXES)
   ) u_decode (
      .instr_bytes(in_data_ff),
      .result     (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.instr_bytes;
      end
      if (out_take && in_valid_ff) begin
         out_data_ff <= decoded;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.is_call       = out_data_ff.is_call;
   assign rsp.is_abs_branch = out_data_ff.is_abs_branch;
   assign rsp.is_rel_branch = out_data_ff.is_rel_branch;
   assign rsp.is_cond       = out_data_ff.is_cond;
   assign rsp.disp_size     = out_data_ff.disp_size;
   assign rsp.disp_offset   = out_data_ff.disp_offset;
   assign rsp.instr_length  = out_data_ff.instr_length;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the x86 branch instruction classifier: directed and random
// instruction windows, checked against a predictor of the classification.
// Depends on xbic_pkg, the xbic_req_if/xbic_rsp_if channels and the RTL top level.
module tb;
   import xbic_pkg::*;

   localparam int unsigned PFX_LIMIT    = 4;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned BLOCK_ITEMS  = 100;

   // Opcodes that look like branches but are not classified as such.
   localparam logic [7:0] OP_RET_FAR_IMM = 8'hCA;
   localparam logic [7:0] OP_RET_FAR     = 8'hCB;
   localparam logic [7:0] OP_ICEBP       = 8'hF1;
   localparam logic [7:0] OP2_SETO       = 8'h90;

   // ModRM reg values of the FF group that do not branch.
   localparam logic [2:0] REG_INC   = 3'd0;
   localparam logic [2:0] REG_DEC   = 3'd1;
   localparam logic [2:0] REG_PUSH  = 3'd6;
   localparam logic [2:0] REG_UNDEF = 3'd7;

   localparam logic [7:0] PREFIX_SET [11] = '{
      PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
      PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP};

   localparam logic [7:0] BRANCH_OPS [12] = '{
      OP_JCC_SHORT_LO, OP_JMP_FAR, OP_RET_IMM, OP_RET, OP_CALL_REL, OP_ENTER,
      OP_CALL_FAR, OP_GROUP5, OP_JMP_REL8, OP_JMP_REL32, OP_ESCAPE, OP_JECXZ};

   typedef struct {
      logic [INSTR_WIDTH-1:0] word;
      xbic_result_type        cls;
   } pending_class_type;

   logic              clock;
   logic              reset;
   pending_class_type pending_classes [$];
   pending_class_type oldest;
   int unsigned       mismatches;
   int unsigned       quiet_cycles;
   logic              sender_idles;
   logic              receiver_idles;

   xbic_req_if req_ch ();
   xbic_rsp_if rsp_ch ();

   x86_branch_instruction_classifier dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic skippable(input logic [7:0] b);
      return b inside {PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                       PFX_OPSIZE, PFX_ADSIZE, PFX_LOCK, PFX_REPNE, PFX_REP};
   endfunction

   function automatic xbic_result_type classify_branch(input logic [INSTR_WIDTH-1:0] word);
      xbic_result_type r;
      int unsigned     pos;
      logic [7:0]      op;
      logic [7:0]      next_byte;
      logic [2:0]      modrm_reg;
      r = '0;
      pos = 0;
      while (pos < PFX_LIMIT && skippable(word[pos*8 +: 8]))
         pos++;
      op        = word[pos*8 +: 8];
      next_byte = word[(pos+1)*8 +: 8];
      modrm_reg = next_byte[5:3];
      if (op >= OP_JCC_SHORT_LO && op <= OP_JCC_SHORT_HI) begin
         r.is_cond       = 1'b1;
         r.is_rel_branch = 1'b1;
         r.disp_size     = DISP_SIZE_8;
         r.disp_offset   = 3'(pos + 1);
      end else begin
         case (op)
            OP_JMP_FAR, OP_RET_IMM, OP_RET: r.is_abs_branch = 1'b1;
            OP_CALL_REL: begin
               r.is_call       = 1'b1;
               r.is_rel_branch = 1'b1;
               r.disp_size     = DISP_SIZE_32;
               r.disp_offset   = 3'(pos + 1);
            end
            OP_ENTER, OP_CALL_FAR: begin
               r.is_call       = 1'b1;
               r.is_abs_branch = 1'b1;
            end
            OP_GROUP5: begin
               if (modrm_reg == REG_CALL_NEAR || modrm_reg == REG_CALL_FAR) begin
                  r.is_call       = 1'b1;
                  r.is_abs_branch = 1'b1;
               end else if (modrm_reg == REG_JMP_NEAR || modrm_reg == REG_JMP_FAR) begin
                  r.is_abs_branch = 1'b1;
               end
            end
            OP_JMP_REL8: begin
               r.is_rel_branch = 1'b1;
               r.disp_size     = DISP_SIZE_8;
               r.disp_offset   = 3'(pos + 1);
            end
            OP_JMP_REL32: begin
               r.is_rel_branch = 1'b1;
               r.disp_size     = DISP_SIZE_32;
               r.disp_offset   = 3'(pos + 1);
            end
            OP_ESCAPE: begin
               if (next_byte[7:4] == OP2_JCC_NEAR_HI) begin
                  r.is_cond       = 1'b1;
                  r.is_rel_branch = 1'b1;
                  r.disp_size     = DISP_SIZE_32;
                  r.disp_offset   = 3'(pos + 2);
               end
            end
            OP_JECXZ: begin
               r.is_cond       = 1'b1;
               r.is_rel_branch = 1'b1;
               r.disp_size     = DISP_SIZE_8;
               r.disp_offset   = 3'(pos + 1);
            end
            default: ;
         endcase
      end
      if (r.is_rel_branch)
         r.instr_length = 4'(r.disp_offset) + 4'(r.disp_size);
      return r;
   endfunction

   // Keeps the low n bytes of lead and fills the rest of the window at random.
   function automatic logic [INSTR_WIDTH-1:0] with_tail(input logic [INSTR_WIDTH-1:0] lead,
                                                        input int unsigned n);
      logic [INSTR_WIDTH-1:0] word;
      word = {$urandom, $urandom};
      for (int unsigned i = 0; i < n; i++)
         word[i*8 +: 8] = lead[i*8 +: 8];
      return word;
   endfunction

   // Mostly prefixes followed by a branch opcode, with some plain noise.
   function automatic logic [INSTR_WIDTH-1:0] random_instr();
      logic [INSTR_WIDTH-1:0] word;
      int unsigned            pos;
      int unsigned            prefixes;
      int unsigned            kind;
      word = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      if (kind < 2)
         return word;
      prefixes = $urandom_range(0, 5);
      for (pos = 0; pos < prefixes; pos++)
         word[pos*8 +: 8] = PREFIX_SET[$urandom_range(0, 10)];
      if (kind < 9) begin
         word[pos*8 +: 8] = BRANCH_OPS[$urandom_range(0, 11)];
         if (word[pos*8 +: 8] == OP_JCC_SHORT_LO)
            word[pos*8 +: 4] = 4'($urandom);
         if (word[pos*8 +: 8] == OP_ESCAPE && $urandom_range(0, 3) != 0)
            word[(pos+1)*8 + 4 +: 4] = OP2_JCC_NEAR_HI;
      end
      return word;
   endfunction

   task automatic send_instr(input logic [INSTR_WIDTH-1:0] word);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.instr_bytes <= word;
      do @(posedge clock); while (!req_ch.ready);
      pending_classes.push_back('{word, classify_branch(word)});
   endtask

   // Holds the input off until every outstanding classification has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_classes.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [INSTR_WIDTH-1:0] word,
                              input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s for %h: expected %0d, actual %0d", $time, name, word, want, got);
         mismatches++;
      end
   endtask

   task automatic test_directed();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      // Leading bytes are listed last-first, as they sit in the window.
      send_instr('0);
      send_instr('1);
      send_instr(with_tail({8'h12, OP_JCC_SHORT_LO}, 2));
      send_instr(with_tail({8'hFE, OP_JCC_SHORT_HI}, 2));
      send_instr(with_tail(OP_JMP_FAR, 1));
      send_instr(with_tail(OP_RET_IMM, 1));
      send_instr(with_tail(OP_RET, 1));
      send_instr(with_tail(OP_CALL_REL, 1));
      send_instr(with_tail(OP_ENTER, 1));
      send_instr(with_tail(OP_CALL_FAR, 1));
      send_instr(with_tail({2'b00, REG_CALL_NEAR, 3'b010, OP_GROUP5}, 2));
      send_instr(with_tail({2'b11, REG_CALL_FAR, 3'b101, OP_GROUP5}, 2));
      send_instr(with_tail({2'b01, REG_JMP_NEAR, 3'b000, OP_GROUP5}, 2));
      send_instr(with_tail({2'b10, REG_JMP_FAR, 3'b111, OP_GROUP5}, 2));
      send_instr(with_tail({2'b11, REG_INC, 3'b000, OP_GROUP5}, 2));
      send_instr(with_tail({2'b00, REG_DEC, 3'b011, OP_GROUP5}, 2));
      send_instr(with_tail({2'b01, REG_PUSH, 3'b110, OP_GROUP5}, 2));
      send_instr(with_tail({2'b11, REG_UNDEF, 3'b111, OP_GROUP5}, 2));
      send_instr(with_tail(OP_JMP_REL8, 1));
      send_instr(with_tail(OP_JMP_REL32, 1));
      send_instr(with_tail({OP2_JCC_NEAR_HI, 4'h0, OP_ESCAPE}, 2));
      send_instr(with_tail({OP2_JCC_NEAR_HI, 4'hF, OP_ESCAPE}, 2));
      send_instr(with_tail({OP2_SETO, OP_ESCAPE}, 2));
      send_instr(with_tail(OP_JECXZ, 1));
      // Four prefixes before a near conditional jump give the longest result.
      send_instr(with_tail({OP2_JCC_NEAR_HI, 4'h5, OP_ESCAPE,
                            PFX_OPSIZE, PFX_CS, PFX_REPNE, PFX_LOCK}, 6));
      send_instr(with_tail({OP_JMP_REL32, PFX_ADSIZE, PFX_GS}, 3));
      // A fifth prefix byte is taken as the opcode.
      send_instr(with_tail({OP_CALL_REL, PFX_REP, PFX_REP, PFX_REP, PFX_REP, PFX_REP}, 6));
      send_instr(with_tail(OP_RET_FAR_IMM, 1));
      send_instr(with_tail(OP_RET_FAR, 1));
      send_instr(with_tail(OP_ICEBP, 1));
   endtask

   task automatic test_drain_pause();
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      repeat (16) send_instr(random_instr());
      wait_drained();
      receiver_idles = 1'b0;
      repeat (16) send_instr(random_instr());
      wait_drained();
   endtask

   task automatic test_random();
      int unsigned mode;
      for (int unsigned blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         // Each block picks which sides idle, so some run back to back.
         mode           = $urandom_range(0, 3);
         sender_idles   = mode[0];
         receiver_idles = mode[1];
         repeat (BLOCK_ITEMS) send_instr(random_instr());
         if ($urandom_range(0, 2) == 0)
            wait_drained();
      end
   endtask

   // Result side: when receiver_idles is set, may stall before each transfer; then waits for it.
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, 5) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_classes.size() == 0) begin
            $display("%0t: result with none expected: call %0d abs %0d rel %0d cond %0d", $time,
                     rsp_ch.is_call, rsp_ch.is_abs_branch, rsp_ch.is_rel_branch,
                     rsp_ch.is_cond);
            mismatches++;
         end else begin
            oldest = pending_classes.pop_front();
            check_field("is_call", oldest.word, oldest.cls.is_call, rsp_ch.is_call);
            check_field("is_abs_branch", oldest.word, oldest.cls.is_abs_branch,
                        rsp_ch.is_abs_branch);
            check_field("is_rel_branch", oldest.word, oldest.cls.is_rel_branch,
                        rsp_ch.is_rel_branch);
            check_field("is_cond", oldest.word, oldest.cls.is_cond, rsp_ch.is_cond);
            check_field("disp_size", oldest.word, oldest.cls.disp_size, rsp_ch.disp_size);
            check_field("disp_offset", oldest.word, oldest.cls.disp_offset,
                        rsp_ch.disp_offset);
            check_field("instr_length", oldest.word, oldest.cls.instr_length,
                        rsp_ch.instr_length);
         end
      end
   end

   // Ends the run if neither channel has a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.instr_bytes = '0;
      mismatches         = 0;
      quiet_cycles       = 0;
      sender_idles       = 1'b0;
      receiver_idles     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random();
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_classes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
